// ===== sv/chunk_residency_window_manager_assert.svh =====
// Assertion helpers for the chunk residency window manager.
`ifndef CHUNK_RESIDENCY_WINDOW_MANAGER_ASSERT_SVH
`define CHUNK_RESIDENCY_WINDOW_MANAGER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CRW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/crw_pkg.sv =====
package crw_pkg;

  localparam int TABLE_DEPTH_DEF = 128;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_PITCH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_REACH  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOADS   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_TIME   = 8'd3;

  localparam logic [23:0] GRID_PITCH_RST  = 24'd25600;
  localparam logic [1:0]  RING_REACH_RST  = 2'd2;
  localparam logic [7:0]  MAX_LOADS_RST   = 8'd1;
  localparam logic [15:0] LOAD_TIME_RST   = 16'd128;

  // 100.0 in 8 fraction bits, used when the pitch register is zero
  localparam logic [23:0] DEFAULT_CHUNK = 24'd25600;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_UNLOAD = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  localparam logic [1:0] PH_UNLOADING = 2'd0;
  localparam logic [1:0] PH_QUEUED    = 2'd1;
  localparam logic [1:0] PH_LOADING   = 2'd2;
  localparam logic [1:0] PH_LOADED    = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] viewer_x;
    logic signed [31:0] viewer_y;
    logic signed [15:0] time_step;
    logic signed [23:0] chunk_x;
    logic signed [23:0] chunk_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] loaded_count;
    logic [7:0] loading_count;
    logic [1:0] chunk_state;
    logic       overflow;
  } out_item_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_DIV_X,
    CMD_DIV_Y,
    CMD_TAKE_VX,
    CMD_TAKE_VY,
    CMD_WIN_INIT,
    CMD_SCAN_INIT,
    CMD_RD_IDX,
    CMD_CMP_KEY,
    CMD_APPEND,
    CMD_WIN_NEXT,
    CMD_AGE,
    CMD_RD_LAST,
    CMD_MOVE,
    CMD_NEXT,
    CMD_CNT_BUSY,
    CMD_PROMOTE,
    CMD_CLEAR,
    CMD_OUT
  } dp_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       idx_end;
    logic       found;
    logic       rd_unld;
    logic       win_last;
    logic       out_free;
    logic [1:0] mode;
  } dp_stat_t;

endpackage

// ===== sv/chunk_residency_window_manager.sv =====
// Channel | Direction | Payload
// in_     | input     | crw_pkg::in_item_t (mode, viewer, time step, chunk)
// out_    | output    | crw_pkg::out_item_t (counts, chunk state, overflow)
// cfg_    | input     | 8-bit register index, 24-bit write data
//
// One item at a time. A tick runs two 32-step floor divisions, a lookup scan
// per window chunk (appending the chunk if it is absent), and four passes over
// the entries (age, remove, count, promote).
// Unload and query take a lookup scan and the count and promote passes.
// Reset is synchronous, active low, and empties the table at once.
// The single-port entry memory sets the pace; a stalled output holds only the final handoff.
`include "chunk_residency_window_manager_assert.svh"

module chunk_residency_window_manager #(
  parameter int TABLE_DEPTH = crw_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  crw_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output crw_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crw_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import crw_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [10:0] count_sum;

  // Registers accept a write every cycle; write them only while no item is in flight.
  assign cfg_ready = 1'b1;

  // Sequence the passes over the entry table.
  crw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the table memory, divider, counters and result register.
  crw_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign count_sum = {3'd0, out_data.loaded_count} + {3'd0, out_data.loading_count};

  // Drop ready right after taking an item.
  `CRW_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "item taken while busy")

  // Loaded plus loading never exceeds the table size.
  `CRW_ASSERT_SAME(a_count_bound, out_valid, count_sum <= 11'(TABLE_DEPTH), "counts exceed table")
endmodule

// ===== sv/crw_div.sv =====
module crw_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic [23:0]        divisor,
  output logic               done,
  output logic [23:0]        quot
);
  import crw_pkg::*;

  logic        busy_r, done_r, neg_r;
  logic [4:0]  cnt_r;
  logic [23:0] rem_r, div_r;
  logic [31:0] quo_r;
  logic [24:0] shifted, trial;
  logic [31:0] qfix;

  assign shifted = {rem_r, quo_r[31]};
  assign trial   = shifted - {1'b0, div_r};
  // floor for negative dividends: -q - (rem != 0) = ~q + (rem == 0)
  assign qfix    = neg_r ? (~quo_r + {31'd0, (rem_r == 24'd0)}) : quo_r;
  assign quot    = qfix[23:0];
  assign done    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      neg_r  <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      div_r  <= DEFAULT_CHUNK;
      quo_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        neg_r  <= dividend[31];
        quo_r  <= dividend[31] ? (~dividend + 32'd1) : dividend;
        rem_r  <= '0;
        cnt_r  <= '0;
        div_r  <= (divisor == 24'd0) ? DEFAULT_CHUNK : divisor;
      end else if (busy_r) begin
        rem_r <= trial[24] ? shifted[23:0] : trial[23:0];
        quo_r <= {quo_r[30:0], ~trial[24]};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== sv/crw_dp.sv =====
module crw_dp #(
  parameter int TABLE_DEPTH = crw_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  crw_pkg::dp_cmd_t                 cmd,
  output crw_pkg::dp_stat_t                stat,
  input  crw_pkg::in_item_t                in_data,
  input  logic                             cfg_valid,
  input  logic [crw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                             out_valid,
  input  logic                             out_ready,
  output crw_pkg::out_item_t               out_data
);
  import crw_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [47:0] coords;
    logic [1:0]  phase;
    logic [15:0] timer;
  } entry_t;

  entry_t mem [TABLE_DEPTH];

  logic [23:0] grid_pitch_r;
  logic [1:0]  ring_reach_r;
  logic [7:0]  max_loads_r;
  logic [15:0] load_time_r;

  in_item_t    item_r;
  logic [23:0] vx_r, vy_r;
  logic [2:0]  cx_r, cy_r;
  logic [CW-1:0] idx_r, total_r, busy_r, loaded_r;
  logic        found_r, ovf_r;
  logic [1:0]  found_ph_r;
  entry_t      rdata_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic        div_start, div_done;
  logic [23:0] div_q;
  logic signed [31:0] div_in;

  logic [23:0] r24, wkey_x, wkey_y;
  logic [47:0] key;
  logic [2:0]  span;
  logic        win_last, is_tick, can_promote, full;
  logic [14:0] dt;
  logic [16:0] tsum;
  logic [15:0] tsat;
  logic [7:0]  limit;
  logic [CW-1:0] total_m1;
  entry_t      aged, wr_data;
  logic        wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [1:0]  st_out;

  function automatic logic near(input logic [23:0] a, input logic [23:0] b,
                                input logic [1:0] r);
    logic [23:0]        d;
    logic signed [24:0] ds, rs;
    d  = a - b;
    ds = {d[23], d};
    rs = {23'd0, r};
    return (ds <= rs) && (ds >= -rs);
  endfunction

  assign div_start = (cmd == CMD_DIV_X) || (cmd == CMD_DIV_Y);
  assign div_in    = (cmd == CMD_DIV_X) ? item_r.viewer_x : item_r.viewer_y;

  crw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in),
    .divisor  (grid_pitch_r),
    .done     (div_done),
    .quot     (div_q)
  );

  assign is_tick  = (item_r.mode == MODE_TICK);
  assign r24      = {22'd0, ring_reach_r};
  assign wkey_x   = vx_r - r24 + {21'd0, cx_r};
  assign wkey_y   = vy_r - r24 + {21'd0, cy_r};
  assign key      = is_tick ? {wkey_y, wkey_x} : {item_r.chunk_y, item_r.chunk_x};
  assign span     = {ring_reach_r, 1'b0};
  assign win_last = (cx_r == span) && (cy_r == span);
  assign full     = (total_r == CW'(TABLE_DEPTH));
  assign total_m1 = total_r - {{(CW-1){1'b0}}, 1'b1};

  assign dt   = item_r.time_step[15] ? 15'd0 : item_r.time_step[14:0];
  assign tsum = {1'b0, rdata_r.timer} + {2'b00, dt};
  assign tsat = tsum[16] ? 16'hFFFF : tsum[15:0];

  assign limit       = (max_loads_r == 8'd0) ? 8'd1 : max_loads_r;
  assign can_promote = 16'(busy_r) < 16'(limit);

  always_comb begin
    aged = rdata_r;
    if (rdata_r.phase == PH_LOADING) begin
      if (tsat >= load_time_r) begin
        aged.phase = PH_LOADED;
        aged.timer = 16'd0;
      end else begin
        aged.timer = tsat;
      end
    end else if (!(near(rdata_r.coords[23:0], vx_r, ring_reach_r) &&
                   near(rdata_r.coords[47:24], vy_r, ring_reach_r))) begin
      aged.phase = PH_UNLOADING;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r[AW-1:0];
    wr_data = rdata_r;
    rd_en   = 1'b0;
    rd_addr = idx_r[AW-1:0];
    unique case (cmd)
      CMD_APPEND: begin
        wr_en   = !full;
        wr_addr = total_r[AW-1:0];
        wr_data = '{coords: key, phase: PH_QUEUED, timer: 16'd0};
      end
      CMD_AGE:  begin
        wr_en   = 1'b1;
        wr_data = aged;
      end
      CMD_MOVE: wr_en = 1'b1;
      CMD_PROMOTE: begin
        wr_en   = is_tick && (rdata_r.phase == PH_QUEUED) && can_promote;
        wr_data = '{coords: rdata_r.coords, phase: PH_LOADING, timer: 16'd0};
      end
      CMD_RD_IDX: rd_en = 1'b1;
      CMD_RD_LAST: begin
        rd_en   = 1'b1;
        rd_addr = total_m1[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_LATCH) item_r <= in_data;
    if (cmd == CMD_TAKE_VX) vx_r <= div_q;
    if (cmd == CMD_TAKE_VY) vy_r <= div_q;
  end

  // found_ph_r is cleared per item and only set by a matching compare
  assign st_out = (item_r.mode == MODE_QUERY) ? found_ph_r : PH_UNLOADING;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_pitch_r  <= GRID_PITCH_RST;
      ring_reach_r  <= RING_REACH_RST;
      max_loads_r   <= MAX_LOADS_RST;
      load_time_r   <= LOAD_TIME_RST;
      cx_r          <= '0;
      cy_r          <= '0;
      idx_r         <= '0;
      total_r       <= '0;
      busy_r        <= '0;
      loaded_r      <= '0;
      found_r       <= 1'b0;
      found_ph_r    <= PH_UNLOADING;
      ovf_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      out_r         <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_GRID_PITCH:  grid_pitch_r  <= cfg_wdata;
          CFG_RING_REACH:  ring_reach_r  <= cfg_wdata[1:0];
          CFG_MAX_LOADS:   max_loads_r   <= cfg_wdata[7:0];
          CFG_LOAD_TIME:   load_time_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      unique case (cmd)
        CMD_LATCH: begin
          busy_r     <= '0;
          loaded_r   <= '0;
          found_r    <= 1'b0;
          found_ph_r <= PH_UNLOADING;
          ovf_r      <= 1'b0;
        end
        CMD_WIN_INIT: begin
          cx_r <= '0;
          cy_r <= '0;
        end
        CMD_SCAN_INIT: begin
          idx_r   <= '0;
          found_r <= 1'b0;
        end
        CMD_CMP_KEY: begin
          if (rdata_r.coords == key) begin
            found_r    <= 1'b1;
            found_ph_r <= rdata_r.phase;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        CMD_APPEND: begin
          if (full) ovf_r <= 1'b1;
          else total_r <= total_r + CW'(1);
        end
        CMD_WIN_NEXT: begin
          if (cx_r == span) begin
            cx_r <= '0;
            cy_r <= cy_r + 3'd1;
          end else begin
            cx_r <= cx_r + 3'd1;
          end
        end
        CMD_AGE, CMD_NEXT: idx_r <= idx_r + CW'(1);
        CMD_MOVE: total_r <= total_m1;
        CMD_CNT_BUSY: begin
          if (rdata_r.phase == PH_LOADING) busy_r <= busy_r + CW'(1);
          idx_r <= idx_r + CW'(1);
        end
        CMD_PROMOTE: begin
          if (wr_en) busy_r <= busy_r + CW'(1);
          if (rdata_r.phase == PH_LOADED) loaded_r <= loaded_r + CW'(1);
          idx_r <= idx_r + CW'(1);
        end
        CMD_CLEAR: total_r <= '0;
        default: ;
      endcase
      if (cmd == CMD_OUT) begin
        out_valid_r <= 1'b1;
        out_r       <= '{loaded_count: 8'(loaded_r), loading_count: 8'(busy_r),
                         chunk_state: st_out, overflow: ovf_r};
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat = '{div_done: div_done, idx_end: (idx_r == total_r), found: found_r,
                  rd_unld: (rdata_r.phase == PH_UNLOADING), win_last: win_last,
                  out_free: (!out_valid_r || out_ready), mode: item_r.mode};
endmodule

// ===== sv/crw_ctrl.sv =====
module crw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  crw_pkg::dp_stat_t stat,
  output crw_pkg::dp_cmd_t  cmd
);
  import crw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_DIVX_GO, S_DIVX_WAIT, S_DIVY_GO, S_DIVY_WAIT,
    S_WIN_INIT, S_W_SCAN, S_W_TEST, S_W_CMP, S_W_ADD, S_W_NEXT,
    S_AGE_INIT, S_AGE_TEST, S_AGE_UPD,
    S_RM_INIT, S_RM_TEST, S_RM_CHK, S_RM_MOVE,
    S_CNT_INIT, S_CNT_TEST, S_CNT_UPD,
    S_PR_INIT, S_PR_TEST, S_PR_UPD,
    S_F_INIT, S_F_TEST, S_F_CMP, S_F_ACT, S_F_LAST, S_F_MOVE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd       = CMD_LATCH;
        state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat.mode)
          MODE_TICK:  state_nxt = S_DIVX_GO;
          MODE_CLEAR: begin
            cmd       = CMD_CLEAR;
            state_nxt = S_CNT_INIT;
          end
          default:    state_nxt = S_F_INIT;
        endcase
      end
      S_DIVX_GO: begin
        cmd       = CMD_DIV_X;
        state_nxt = S_DIVX_WAIT;
      end
      S_DIVX_WAIT: if (stat.div_done) begin
        cmd       = CMD_TAKE_VX;
        state_nxt = S_DIVY_GO;
      end
      S_DIVY_GO: begin
        cmd       = CMD_DIV_Y;
        state_nxt = S_DIVY_WAIT;
      end
      S_DIVY_WAIT: if (stat.div_done) begin
        cmd       = CMD_TAKE_VY;
        state_nxt = S_WIN_INIT;
      end
      S_WIN_INIT: begin
        cmd       = CMD_WIN_INIT;
        state_nxt = S_W_SCAN;
      end
      S_W_SCAN: begin
        cmd       = CMD_SCAN_INIT;
        state_nxt = S_W_TEST;
      end
      S_W_TEST: begin
        if (stat.found || stat.idx_end) state_nxt = S_W_ADD;
        else begin
          cmd       = CMD_RD_IDX;
          state_nxt = S_W_CMP;
        end
      end
      S_W_CMP: begin
        cmd       = CMD_CMP_KEY;
        state_nxt = S_W_TEST;
      end
      S_W_ADD: begin
        if (!stat.found) cmd = CMD_APPEND;
        state_nxt = S_W_NEXT;
      end
      S_W_NEXT: begin
        cmd       = CMD_WIN_NEXT;
        state_nxt = stat.win_last ? S_AGE_INIT : S_W_SCAN;
      end
      S_AGE_INIT: begin
        cmd       = CMD_SCAN_INIT;
        state_nxt = S_AGE_TEST;
      end
      S_AGE_TEST: begin
        if (stat.idx_end) state_nxt = S_RM_INIT;
        else begin
          cmd       = CMD_RD_IDX;
          state_nxt = S_AGE_UPD;
        end
      end
      S_AGE_UPD: begin
        cmd       = CMD_AGE;
        state_nxt = S_AGE_TEST;
      end
      S_RM_INIT: begin
        cmd       = CMD_SCAN_INIT;
        state_nxt = S_RM_TEST;
      end
      S_RM_TEST: begin
        if (stat.idx_end) state_nxt = S_CNT_INIT;
        else begin
          cmd       = CMD_RD_IDX;
          state_nxt = S_RM_CHK;
        end
      end
      S_RM_CHK: begin
        if (stat.rd_unld) begin
          cmd       = CMD_RD_LAST;
          state_nxt = S_RM_MOVE;
        end else begin
          cmd       = CMD_NEXT;
          state_nxt = S_RM_TEST;
        end
      end
      S_RM_MOVE: begin
        cmd       = CMD_MOVE;
        state_nxt = S_RM_TEST;
      end
      S_CNT_INIT: begin
        cmd       = CMD_SCAN_INIT;
        state_nxt = S_CNT_TEST;
      end
      S_CNT_TEST: begin
        if (stat.idx_end) state_nxt = S_PR_INIT;
        else begin
          cmd       = CMD_RD_IDX;
          state_nxt = S_CNT_UPD;
        end
      end
      S_CNT_UPD: begin
        cmd       = CMD_CNT_BUSY;
        state_nxt = S_CNT_TEST;
      end
      S_PR_INIT: begin
        cmd       = CMD_SCAN_INIT;
        state_nxt = S_PR_TEST;
      end
      S_PR_TEST: begin
        if (stat.idx_end) state_nxt = S_DONE;
        else begin
          cmd       = CMD_RD_IDX;
          state_nxt = S_PR_UPD;
        end
      end
      S_PR_UPD: begin
        cmd       = CMD_PROMOTE;
        state_nxt = S_PR_TEST;
      end
      S_F_INIT: begin
        cmd       = CMD_SCAN_INIT;
        state_nxt = S_F_TEST;
      end
      S_F_TEST: begin
        if (stat.found || stat.idx_end) state_nxt = S_F_ACT;
        else begin
          cmd       = CMD_RD_IDX;
          state_nxt = S_F_CMP;
        end
      end
      S_F_CMP: begin
        cmd       = CMD_CMP_KEY;
        state_nxt = S_F_TEST;
      end
      S_F_ACT: begin
        if (stat.found && stat.mode == MODE_UNLOAD) state_nxt = S_F_LAST;
        else state_nxt = S_CNT_INIT;
      end
      S_F_LAST: begin
        cmd       = CMD_RD_LAST;
        state_nxt = S_F_MOVE;
      end
      S_F_MOVE: begin
        cmd       = CMD_MOVE;
        state_nxt = S_CNT_INIT;
      end
      S_DONE: if (stat.out_free) begin
        cmd       = CMD_OUT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
